@@ rtl/core/bb3_pkg.sv @@
// shared types and constants of the 3x3 box blur stream
package bb3_pkg;

  // field widths
  localparam int FW_W  = 13;
  localparam int FH_W  = 16;
  localparam int PIX_W = 8;
  localparam int ROW_W = 16;
  localparam int COL_W = 12;
  localparam int SUM_W = 12;

  // default geometry and line store size
  localparam int              MAX_WIDTH_DEF    = 4096;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  // register indexes on the config port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // result queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // divide by 9 as multiply by ceil(2^16/9) and shift
  localparam logic [12:0] DIV9_MUL   = 13'd7282;
  localparam int          DIV9_SHIFT = 16;

  // result slots of one pixel, in emit order
  localparam int SLOT_PREV_LEFT = 0;  // row y-1, column x-1
  localparam int SLOT_PREV_END  = 1;  // row y-1, column x at end of row
  localparam int SLOT_CUR       = 2;  // pixel on last row or tiny frame

  // one queued pixel with up to three results
  typedef struct packed {
    logic [2:0]       en;
    logic             avg;
    logic             frame_end;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [SUM_W-1:0] v1;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] pix;
  } bb3_entry_t;

endpackage

@@ rtl/core/box_blur_3x3_stream.sv @@
// 3x3 box blur over a raster pixel stream, top level with config registers
// path: a pixel's first result passes the window stage register and the result
//   queue; its further results follow one per cycle while out_stall is low
// throughput: one pixel per cycle in, one result per cycle out while out_stall
//   is low; the queue absorbs the extra row end result; the input stalls only
//   once it fills, as on the last row: two results per pixel (half rate)
// reset: clears counters, window, queue and output valid; geometry returns to
//   640x480; the line store is not cleared and holds data only once written
module box_blur_3x3_stream #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bb3_pkg::PIX_W-1:0]   pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bb3_pkg::PIX_W-1:0]   pixel_out,
  output logic [bb3_pkg::ROW_W-1:0]   out_row,
  output logic [bb3_pkg::COL_W-1:0]   out_col,
  output logic                        last_of_step,
  output logic                        last_of_frame
);
  import bb3_pkg::*;

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            cfg_write;
  logic            q_full;
  logic            q_push;
  logic            q_valid;
  logic            q_pop;
  bb3_entry_t      push_entry;
  bb3_entry_t      head_entry;

  // config registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
    endcase
  end

  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_in     (pixel_in),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  bb3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .valid     (q_valid),
    .data      (head_entry),
    .pop       (q_pop)
  );

  bb3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (head_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_out     (pixel_out),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_step  (last_of_step),
    .last_of_frame (last_of_frame)
  );

endmodule

@@ rtl/core/bb3_front.sv @@
// front end: pixel accept, raster counters, line store, window and sum
module bb3_front #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bb3_pkg::FW_W-1:0]      frame_width,
  input  logic [bb3_pkg::FH_W-1:0]      frame_height,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bb3_pkg::PIX_W-1:0]     pixel_in,
  input  logic                          q_full,
  output logic                          q_push,
  output bb3_pkg::bb3_entry_t           q_entry
);
  import bb3_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int AW = XW + 1;
  localparam int WW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

  logic [XW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [WW-1:0]    w_eff;
  logic [WW-1:0]    x_ext;
  logic [FH_W-1:0]  h_eff;
  logic             end_row;
  logic             end_frame;
  logic             tiny_frame;
  logic             accept;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    prev_addr;
  logic [2:0]       en_next;
  logic             border_next;

  logic [PIX_W-1:0] line_mem [2**AW];

  logic             b_valid;
  logic [2:0]       b_en;
  logic             b_border;
  logic             b_frame_end;
  logic [ROW_W-1:0] b_row;
  logic [COL_W-1:0] b_col;
  logic [PIX_W-1:0] b_pix;
  logic [PIX_W-1:0] top_rd;
  logic [PIX_W-1:0] mid_rd;
  logic             b_any;
  logic             b_go;

  logic [PIX_W-1:0] win [6];
  logic [SUM_W-1:0] sum;

  // effective geometry
  always_comb begin
    priority if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  // position classification of the incoming pixel
  always_comb begin
    x_ext      = WW'(col_count);
    end_row    = x_ext >= (w_eff - WW'(1));
    end_frame  = end_row && (row_count >= (h_eff - FH_W'(1)));
    tiny_frame = (w_eff < WW'(3)) || (h_eff < FH_W'(3));
    en_next[SLOT_PREV_LEFT] = !tiny_frame && (row_count != '0) && (col_count != '0);
    en_next[SLOT_PREV_END]  = !tiny_frame && (row_count != '0) && end_row;
    en_next[SLOT_CUR]       = tiny_frame || (row_count >= (h_eff - FH_W'(1)));
    border_next = (row_count == ROW_W'(1)) || (row_count >= h_eff) ||
                  (col_count == XW'(1)) || (x_ext >= w_eff);
    cur_addr  = {row_count[0], col_count};
    prev_addr = {~row_count[0], col_count};
  end

  // handshake between accept stage and window stage
  assign b_any    = b_en != 3'b000;
  assign in_stall = b_valid && b_any && q_full;
  assign b_go     = b_valid && !(b_any && q_full);
  assign q_push   = b_valid && b_any && !q_full;
  assign accept   = in_valid && !in_stall;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (end_row) begin
        col_count <= '0;
        row_count <= end_frame ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + XW'(1);
      end
    end
  end

  // window stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  // line store, read before write at the current address
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[cur_addr] <= pixel_in;
      top_rd             <= line_mem[cur_addr];
      mid_rd             <= line_mem[prev_addr];
      b_en               <= en_next;
      b_border           <= border_next;
      b_frame_end        <= end_frame;
      b_row              <= row_count;
      b_col              <= COL_W'(col_count);
      b_pix              <= pixel_in;
    end
  end

  // window columns shift once per processed pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (b_go) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_rd;
      win[4] <= mid_rd;
      win[5] <= b_pix;
    end
  end

  // 3x3 neighbourhood sum
  assign sum = SUM_W'(win[0]) + SUM_W'(win[1]) + SUM_W'(win[2]) +
               SUM_W'(win[3]) + SUM_W'(win[4]) + SUM_W'(win[5]) +
               SUM_W'(top_rd) + SUM_W'(mid_rd) + SUM_W'(b_pix);

  // queue entry
  always_comb begin
    q_entry.en        = b_en;
    q_entry.avg       = !b_border;
    q_entry.frame_end = b_frame_end;
    q_entry.row       = b_row;
    q_entry.col       = b_col;
    q_entry.v1        = b_border ? SUM_W'(win[4]) : sum;
    q_entry.mid       = mid_rd;
    q_entry.pix       = b_pix;
  end

endmodule

@@ rtl/core/bb3_queue.sv @@
// small result queue between the front and back ends
module bb3_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bb3_pkg::bb3_entry_t push_data,
  output logic                full,
  output logic                valid,
  output bb3_pkg::bb3_entry_t data,
  input  logic                pop
);
  import bb3_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bb3_entry_t    slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign data  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ rtl/core/bb3_back.sv @@
// back end: splits queued pixels into result transactions, divides by 9
module bb3_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  bb3_pkg::bb3_entry_t         q_entry,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bb3_pkg::PIX_W-1:0]   pixel_out,
  output logic [bb3_pkg::ROW_W-1:0]   out_row,
  output logic [bb3_pkg::COL_W-1:0]   out_col,
  output logic                        last_of_step,
  output logic                        last_of_frame
);
  import bb3_pkg::*;

  localparam int PROD_W = SUM_W + 13;

  logic [2:0]        done;
  logic [2:0]        rem;
  logic [2:0]        sel;
  logic              is_last;
  logic              load;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  avg_val;
  logic [PIX_W-1:0]  val_next;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic              frame_next;

  // next result of the head entry
  always_comb begin
    rem = q_entry.en & ~done;
    priority if (rem[SLOT_PREV_LEFT]) begin
      sel = 3'b001 << SLOT_PREV_LEFT;
    end else if (rem[SLOT_PREV_END]) begin
      sel = 3'b001 << SLOT_PREV_END;
    end else begin
      sel = 3'b001 << SLOT_CUR;
    end
    is_last = (rem & ~sel) == 3'b000;
  end

  // truncated mean by reciprocal multiply
  assign prod    = PROD_W'(q_entry.v1) * PROD_W'(DIV9_MUL);
  assign avg_val = prod[DIV9_SHIFT +: PIX_W];

  // result fields
  always_comb begin
    priority if (sel[SLOT_PREV_LEFT]) begin
      val_next   = q_entry.avg ? avg_val : q_entry.v1[PIX_W-1:0];
      row_next   = q_entry.row - ROW_W'(1);
      col_next   = q_entry.col - COL_W'(1);
      frame_next = 1'b0;
    end else if (sel[SLOT_PREV_END]) begin
      val_next   = q_entry.mid;
      row_next   = q_entry.row - ROW_W'(1);
      col_next   = q_entry.col;
      frame_next = 1'b0;
    end else begin
      val_next   = q_entry.pix;
      row_next   = q_entry.row;
      col_next   = q_entry.col;
      frame_next = q_entry.frame_end;
    end
  end

  assign load  = q_valid && (!out_valid || !out_stall);
  assign q_pop = load && is_last;

  // output register valid and slot progress
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= 3'b000;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        done <= 3'b000;
      end else if (load) begin
        done <= done | sel;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_out     <= val_next;
      out_row       <= row_next;
      out_col       <= col_next;
      last_of_step  <= is_last;
      last_of_frame <= frame_next;
    end
  end

  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> last_of_step)
    else $error("frame end not on last result of its pixel");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop without a head entry");
  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (done & ~q_entry.en) == 3'b000)
    else $error("progress mask outside head entry results");

endmodule
